// File: sv/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg
// Shared widths, fixed-point constants and codes of the alpha coverage unit.
// ----------------------------------------------------------------------------
package acp_pkg;

	localparam int ALPHA_W    = 16;  // Q0.16 sample
	localparam int Q_W        = 17;  // Q0.16 value that may reach one
	localparam int TOL_W      = 12;
	localparam int IDX_W      = 12;
	localparam int LOADED_W   = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int DIVIDEND_W = 33;  // reference << 16
	localparam int GAIN_W     = 32;  // Q16.16
	localparam int DIV_CNT_W  = 6;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

	localparam logic [Q_W-1:0]    ONE_Q16  = 17'd65536;
	localparam logic [Q_W-1:0]    HALF_Q16 = 17'd32768;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 32'h0001_0000;

	localparam logic [TOL_W-1:0]  TOL_RESET = 12'd7;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd2;

endpackage

// File: sv/alpha_coverage_preserve_unit.sv
// ----------------------------------------------------------------------------
// alpha_coverage_preserve_unit
// Stores the alpha samples of one mip image, bisects for the threshold that
// keeps the target alpha-test coverage, and reads samples back scaled.
// ----------------------------------------------------------------------------
// A load writes the memory on accept; a read passes the registered memory read,
// the multiply and the output register. A closing load runs the search (or goes
// to the report at target zero): a band step, per round a sweep of the memory's
// single read port and a decide step, then the bit-serial gain divider, and the
// report. One load per cycle when idle; reads and closing loads stall the input.
// Reset: asynchronous; control, bounds, gain and registers return to their
// defaults; the sample memory is not cleared (entries past the count never read).
module alpha_coverage_preserve_unit #(
	parameter int MAX_SAMPLES   = 4096,
	parameter int SEARCH_ROUNDS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [acp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [acp_pkg::Q_W-1:0]       cfg_data,
	// input transaction
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [acp_pkg::ALPHA_W-1:0]   alpha_in,
	input  logic                          last_sample,
	input  logic [acp_pkg::IDX_W-1:0]     read_index,
	// output transaction
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [acp_pkg::ALPHA_W-1:0]   alpha_out,
	output logic [acp_pkg::Q_W-1:0]       threshold_found,
	output logic [acp_pkg::LOADED_W-1:0]  samples_loaded,
	output logic                          overflow
);
	import acp_pkg::*;

	localparam int ADDR_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int TOT_X_W = (CNT_W > LOADED_W) ? CNT_W : LOADED_W;
	localparam int SUM_W   = Q_W + 1;
	localparam int BAND_W  = SUM_W + CNT_W;
	localparam int RND_W   = $clog2(SEARCH_ROUNDS + 1);
	localparam int PROD_W  = ALPHA_W + GAIN_W;

	localparam logic [CNT_W-1:0] MAX_CNT    = CNT_W'(MAX_SAMPLES);
	localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(SEARCH_ROUNDS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BAND,
		ST_SWEEP,
		ST_DECIDE,
		ST_DIV,
		ST_REPORT,
		ST_RD_MUL,
		ST_RD_OUT
	} state_t;

	state_t state_q;

	// registers
	logic [Q_W-1:0]   target_q;
	logic [Q_W-1:0]   reference_q;
	logic [TOL_W-1:0] tolerance_q;

	// image and search state
	logic [CNT_W-1:0]  total_q;
	logic              overflow_q;
	logic              closed_q;
	logic [Q_W-1:0]    low_q;
	logic [Q_W-1:0]    high_q;
	logic [Q_W-1:0]    mid_q;
	logic [GAIN_W-1:0] gain_q;
	logic [BAND_W-1:0] hi_band_q;
	logic [BAND_W-1:0] lo_band_q;
	logic              lo_en_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RND_W-1:0]  round_q;
	logic              div_start_q;

	// memory and read pipeline
	logic [ALPHA_W-1:0] mem [MAX_SAMPLES];
	logic [ALPHA_W-1:0] rdata_s1;
	logic               vld_s1;
	logic               in_range_s1;
	logic [PROD_W-1:0]  prod_s2;
	logic               in_range_s2;

	// output register
	logic               out_valid_q;
	logic               kind_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [Q_W-1:0]     thresh_q;
	logic [LOADED_W-1:0] loaded_q;
	logic               ovf_q;

	logic                  in_acc;
	logic                  slot_free;
	logic                  out_load;
	logic [CNT_W-1:0]      total_eff;
	logic                  room;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [ADDR_W-1:0]     rd_addr;
	logic [CMP_W-1:0]      idx_ext;
	logic [CMP_W-1:0]      total_ext;
	logic [TOT_X_W-1:0]    total_wide;
	logic [BAND_W-1:0]     scaled;
	logic                  too_high;
	logic                  too_low;
	logic [Q_W-1:0]        next_low;
	logic [Q_W-1:0]        next_high;
	logic [SUM_W-1:0]      mid_sum;
	logic [SUM_W-1:0]      band_sum;
	logic [Q_W-1:0]        band_diff;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] quotient;
	logic [Q_W-1:0]        divisor;
	logic [PROD_W-16-1:0]  prod_shr;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	// Fill the output register from the report or the read-out state.
	assign out_load  = slot_free && (state_q == ST_REPORT || state_q == ST_RD_OUT);

	// A load after a closed image starts the count over.
	assign total_eff = closed_q ? '0 : total_q;
	assign room      = total_eff < MAX_CNT;
	assign wr_en     = in_acc && (op == OP_LOAD) && room;
	assign wr_addr   = total_eff[ADDR_W-1:0];

	assign idx_ext   = CMP_W'(read_index);
	assign total_ext = CMP_W'(total_q);
	assign rd_addr   = (state_q == ST_IDLE) ? idx_ext[ADDR_W-1:0] : idx_q[ADDR_W-1:0];

	assign total_wide = TOT_X_W'(total_q);

	assign band_sum  = SUM_W'(target_q) + SUM_W'(tolerance_q);
	assign band_diff = target_q - Q_W'(tolerance_q);

	assign scaled    = BAND_W'({cnt_q, 16'h0000});
	assign too_high  = scaled > hi_band_q;
	assign too_low   = lo_en_q && (scaled < lo_band_q);
	assign next_low  = too_high ? mid_q : low_q;
	assign next_high = (!too_high && too_low) ? mid_q : high_q;
	assign mid_sum   = SUM_W'(next_low) + SUM_W'(next_high);

	assign divisor  = (mid_q == '0) ? Q_W'(1) : mid_q;
	assign prod_shr = prod_s2[PROD_W-1:16];

	acp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend ({reference_q, 16'h0000}),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Sample memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= alpha_in;
		end
		rdata_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			reference_q <= HALF_Q16;
			tolerance_q <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET:    target_q    <= cfg_data;
				CFG_REFERENCE: reference_q <= cfg_data;
				CFG_TOLERANCE: tolerance_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			total_q     <= '0;
			overflow_q  <= 1'b0;
			closed_q    <= 1'b0;
			low_q       <= '0;
			high_q      <= ONE_Q16;
			mid_q       <= HALF_Q16;
			gain_q      <= GAIN_ONE;
			idx_q       <= '0;
			cnt_q       <= '0;
			round_q     <= '0;
			vld_s1      <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Start the divider when the search ends: no move left or last round.
			div_start_q <= (state_q == ST_DECIDE) &&
				(!(too_high || too_low) || (round_q == LAST_ROUND));
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && op == OP_LOAD) begin
						// A closing load marks the image closed.
						closed_q   <= last_sample;
						overflow_q <= (closed_q ? 1'b0 : overflow_q) | !room;
						total_q    <= room ? total_eff + 1'b1 : total_eff;
						if (last_sample) begin
							// Restart the bisection.
							low_q    <= '0;
							high_q   <= ONE_Q16;
							mid_q    <= HALF_Q16;
							round_q  <= '0;
							if (target_q == '0) begin
								gain_q  <= GAIN_ONE;
								state_q <= ST_REPORT;
							end else begin
								state_q <= ST_BAND;
							end
						end
					end else if (in_acc) begin
						in_range_s1 <= idx_ext < total_ext;
						state_q     <= ST_RD_MUL;
					end
				end
				ST_BAND: begin
					// Band limits depend on the count, target and tolerance, not on the midpoint; form them once.
					hi_band_q <= BAND_W'(band_sum * total_q);
					lo_band_q <= BAND_W'(band_diff * total_q);
					lo_en_q   <= target_q > Q_W'(tolerance_q);
					idx_q     <= '0;
					cnt_q     <= '0;
					vld_s1    <= 1'b0;
					state_q   <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (vld_s1 && ({1'b0, rdata_s1} > mid_q)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (idx_q < total_q) begin
						idx_q  <= idx_q + 1'b1;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_DECIDE: begin
					if (too_high || too_low) begin
						low_q   <= next_low;
						high_q  <= next_high;
						mid_q   <= mid_sum[SUM_W-1:1];
						round_q <= round_q + 1'b1;
						idx_q   <= '0;
						cnt_q   <= '0;
						if (round_q == LAST_ROUND) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_SWEEP;
						end
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						// Saturate the gain to 32 bits.
						gain_q  <= quotient[DIVIDEND_W-1] ? '1 : quotient[GAIN_W-1:0];
						state_q <= ST_REPORT;
					end
				end
				ST_REPORT: begin
					if (slot_free) begin
						kind_q      <= KIND_REPORT;
						alpha_q     <= '0;
						thresh_q    <= mid_q;
						loaded_q    <= total_wide[LOADED_W-1:0];
						ovf_q       <= overflow_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_RD_MUL: begin
					prod_s2     <= PROD_W'(rdata_s1 * gain_q);
					in_range_s2 <= in_range_s1;
					state_q     <= ST_RD_OUT;
				end
				ST_RD_OUT: begin
					if (slot_free) begin
						kind_q      <= KIND_SAMPLE;
						if (!in_range_s2) begin
							alpha_q <= '0;
						end else if (prod_shr > (PROD_W-16)'(16'hFFFF)) begin
							alpha_q <= '1;
						end else begin
							alpha_q <= prod_shr[ALPHA_W-1:0];
						end
						thresh_q <= mid_q;
						loaded_q <= total_wide[LOADED_W-1:0];
						ovf_q    <= overflow_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign alpha_out       = alpha_q;
	assign threshold_found = thresh_q;
	assign samples_loaded  = loaded_q;
	assign overflow        = ovf_q;

`ifndef SYNTH
	// The fill count never passes the memory depth.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= MAX_CNT)
		else $error("sample count beyond capacity");

	// The bisection keeps its midpoint between the bounds.
	a_mid_order: assert property (@(posedge clk) disable iff (!arst_n)
		(low_q <= mid_q) && (mid_q <= high_q))
		else $error("bisection bounds out of order");

	// Counted samples never exceed the samples stored.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP || state_q == ST_DECIDE) |-> cnt_q <= total_q)
		else $error("coverage count exceeds sample count");
`endif

endmodule

// File: sv/acp_div.sv
// ----------------------------------------------------------------------------
// acp_div
// Restoring divider, one quotient bit per cycle, for the gain computation.
// ----------------------------------------------------------------------------
module acp_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [acp_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [acp_pkg::Q_W-1:0]        divisor,
	output logic                           done,
	output logic [acp_pkg::DIVIDEND_W-1:0] quotient
);
	import acp_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  step_q;
	logic [Q_W-1:0]        rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [Q_W:0]          trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? Q_W'(trial - {1'b0, divisor}) : trial[Q_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: tb/alpha_coverage_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alpha_coverage_check
// Watches the configuration port and both transaction channels of the alpha
// coverage unit. Models the sample store, the threshold bisection and the
// gain scaling, and compares every output transaction with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module alpha_coverage_check
	import acp_pkg::*;
#(
	parameter int MAX_SAMPLES   = 4096,
	parameter int SEARCH_ROUNDS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [Q_W-1:0]       cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 op,
	input  logic [ALPHA_W-1:0]   alpha_in,
	input  logic                 last_sample,
	input  logic [IDX_W-1:0]     read_index,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 kind,
	input  logic [ALPHA_W-1:0]   alpha_out,
	input  logic [Q_W-1:0]       threshold_found,
	input  logic [LOADED_W-1:0]  samples_loaded,
	input  logic                 overflow,
	output int                   fails,
	output int                   pending
);

	typedef struct packed {
		logic                kind;
		logic [ALPHA_W-1:0]  alpha;
		logic [Q_W-1:0]      thresh;
		logic [LOADED_W-1:0] loaded;
		logic                ovf;
	} acp_result_t;

	acp_result_t        due_results[$];
	logic [ALPHA_W-1:0] alphas[MAX_SAMPLES];
	logic [LOADED_W-1:0] n_stored;
	logic [Q_W-1:0]     lo_bound, hi_bound, mid_bound;
	logic [GAIN_W-1:0]  gain;
	logic               dropped, closed;
	logic [Q_W-1:0]     target, reference;
	logic [TOL_W-1:0]   tolerance;

	// Bisect for the threshold that keeps the target coverage, then set the gain.
	function automatic void bisect_threshold();
		logic [63:0] cnt, scaled, hi_band, lo_band, dvs, g;
		logic        below;
		lo_bound  = '0;
		hi_bound  = ONE_Q16;
		mid_bound = HALF_Q16;
		if (target == 0) begin
			gain = GAIN_ONE;
			return;
		end
		for (int r = 0; r < SEARCH_ROUNDS; r++) begin
			cnt = 0;
			for (int i = 0; i < n_stored; i++)
				if ({1'b0, alphas[i]} > mid_bound) cnt++;
			scaled  = cnt << 16;
			hi_band = (64'(target) + 64'(tolerance)) * 64'(n_stored);
			below   = 1'b0;
			if (target > 17'(tolerance)) begin
				lo_band = 64'(target - 17'(tolerance)) * 64'(n_stored);
				below   = scaled < lo_band;
			end
			if (scaled > hi_band) lo_bound = mid_bound;
			else if (below) hi_bound = mid_bound;
			else break;
			mid_bound = 17'((18'(lo_bound) + 18'(hi_bound)) >> 1);
		end
		dvs  = (mid_bound == 0) ? 64'd1 : 64'(mid_bound);
		g    = (64'(reference) << 16) / dvs;
		gain = (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
	endfunction

	assign pending = due_results.size();

	always @(posedge clk or negedge arst_n) begin
		acp_result_t exp_r, got_r;
		logic [63:0] prod;
		if (!arst_n) begin
			due_results.delete();
			n_stored  = '0;
			lo_bound  = '0;
			hi_bound  = ONE_Q16;
			mid_bound = HALF_Q16;
			gain      = GAIN_ONE;
			dropped   = 1'b0;
			closed    = 1'b0;
			target    = '0;
			reference = HALF_Q16;
			tolerance = TOL_RESET;
			fails     = 0;
		end else begin
			// compare before predicting, so a result never meets its own transaction
			if (out_valid && !out_stall) begin
				got_r = '{kind, alpha_out, threshold_found, samples_loaded, overflow};
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got_r);
					fails++;
				end else begin
					exp_r = due_results.pop_front();
					if (got_r.kind !== exp_r.kind) begin
						$display("%0t: kind exp %0d got %0d", $time, exp_r.kind, got_r.kind);
						fails++;
					end
					if (got_r.alpha !== exp_r.alpha) begin
						$display("%0t: alpha_out exp %0d got %0d", $time, exp_r.alpha,
							got_r.alpha);
						fails++;
					end
					if (got_r.thresh !== exp_r.thresh) begin
						$display("%0t: threshold exp %0d got %0d", $time, exp_r.thresh,
							got_r.thresh);
						fails++;
					end
					if (got_r.loaded !== exp_r.loaded) begin
						$display("%0t: samples_loaded exp %0d got %0d", $time,
							exp_r.loaded, got_r.loaded);
						fails++;
					end
					if (got_r.ovf !== exp_r.ovf) begin
						$display("%0t: overflow exp %0d got %0d", $time, exp_r.ovf, got_r.ovf);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET:    target    = cfg_data;
					CFG_REFERENCE: reference = cfg_data;
					CFG_TOLERANCE: tolerance = cfg_data[TOL_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (op == OP_LOAD) begin
					if (closed) begin
						n_stored = '0;
						dropped  = 1'b0;
						closed   = 1'b0;
					end
					if (n_stored < MAX_SAMPLES) begin
						alphas[n_stored] = alpha_in;
						n_stored++;
					end else begin
						dropped = 1'b1;
					end
					if (last_sample) begin
						bisect_threshold();
						closed = 1'b1;
						due_results.push_back('{KIND_REPORT, '0, mid_bound, n_stored, dropped});
					end
				end else begin
					exp_r = '{KIND_SAMPLE, '0, mid_bound, n_stored, dropped};
					if (read_index < n_stored) begin
						prod = (64'(alphas[read_index]) * 64'(gain)) >> 16;
						exp_r.alpha = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
					end
					due_results.push_back(exp_r);
				end
			end
		end
	end

endmodule

// File: tb/alpha_coverage_preserve_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alpha_coverage_preserve_unit_test
// Drives loads, closing loads and scaled reads into the alpha coverage unit
// with random gaps and output stalls, rewrites the coverage registers between
// images, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module alpha_coverage_preserve_unit_test;
	import acp_pkg::*;

	localparam int  MAX_SAMPLES = 4096;
	localparam int  CYCLE_LIMIT = 3_000_000;
	localparam int  HOLD_CYCLES = 400;
	localparam int  SETTLE      = 60;   // covers a plain load and the read pipeline

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [Q_W-1:0]       cfg_data;
	logic                 in_valid, in_stall;
	logic                 op;
	logic [ALPHA_W-1:0]   alpha_in;
	logic                 last_sample;
	logic [IDX_W-1:0]     read_index;
	logic                 out_valid, out_stall;
	logic                 kind;
	logic [ALPHA_W-1:0]   alpha_out;
	logic [Q_W-1:0]       threshold_found;
	logic [LOADED_W-1:0]  samples_loaded;
	logic                 overflow;

	int fails, pending;
	int cycles;
	int items;
	int tx_gap_max, rx_gap_max;
	int rx_wait;
	bit rx_took;
	bit hold_req;
	int n_img;

	alpha_coverage_preserve_unit DUT (.*);

	alpha_coverage_check CHECK (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_stall, .op, .alpha_in, .last_sample, .read_index,
		.out_valid, .out_stall, .kind, .alpha_out, .threshold_found,
		.samples_loaded, .overflow, .fails, .pending
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: random stall per transaction, plus one long hold-off on request.
	always @(posedge clk)
		if (out_valid && !out_stall) rx_took = 1'b1;

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_took) begin
				rx_took = 1'b0;
				rx_wait = $urandom_range(0, rx_gap_max);
			end
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req  = 1'b0;
				out_stall <= 1'b0;
			end else if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one transaction after a random gap and hold it until accepted.
	task automatic send(input logic o, input logic [ALPHA_W-1:0] a, input logic l,
			input logic [IDX_W-1:0] ix);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op          <= o;
		alpha_in    <= a;
		last_sample <= l;
		read_index  <= ix;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
		items++;
	endtask

	// Drain all predicted results, then let any trailing load finish.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] ix, input logic [Q_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= ix;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [ALPHA_W-1:0] pick_alpha();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'(32768 + $urandom_range(0, 512) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [Q_W-1:0] pick_q();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return ONE_Q16;
			default: return 17'($urandom_range(1, 65535));
		endcase
	endfunction

	// Load an image of the given size, with reads sprinkled in, then read it back.
	task automatic run_image(input int size, input int n_reads);
		for (int i = 0; i < size; i++) begin
			if ($urandom_range(0, 9) == 0)
				send(OP_READ, 16'($urandom), 1'b0, 12'($urandom_range(0, i + 1)));
			send(OP_LOAD, pick_alpha(), i == size - 1, 12'($urandom));
		end
		for (int i = 0; i < n_reads; i++)
			send(OP_READ, 16'($urandom), 1'b0,
				($urandom_range(0, 7) == 0) ? 12'($urandom) : 12'($urandom_range(0, size - 1)));
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_TARGET;
		cfg_data    = '0;
		in_valid    = 1'b0;
		op          = OP_LOAD;
		alpha_in    = '0;
		last_sample = 1'b0;
		read_index  = '0;
		cycles      = 0;
		items       = 0;
		tx_gap_max  = 8;
		rx_gap_max  = 8;
		rx_wait     = 0;
		rx_took     = 1'b0;
		hold_req    = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reads before any load, then pass-through with the search off.
		send(OP_READ, 16'hFFFF, 1'b0, 12'd0);
		send(OP_READ, 16'h0000, 1'b0, 12'hFFF);
		send(OP_LOAD, 16'h0000, 1'b0, 12'hFFF);
		send(OP_LOAD, 16'hFFFF, 1'b0, 12'h000);
		send(OP_LOAD, 16'h8000, 1'b1, 12'h000);
		send(OP_READ, 16'h0000, 1'b0, 12'd0);
		send(OP_READ, 16'h0000, 1'b0, 12'd1);
		send(OP_READ, 16'h0000, 1'b0, 12'd2);
		send(OP_READ, 16'h0000, 1'b0, 12'd3);
		drain();

		// Full target, near-zero image: every round lowers the midpoint and the gain grows large.
		write_reg(CFG_TARGET, ONE_Q16);
		write_reg(CFG_REFERENCE, ONE_Q16);
		write_reg(CFG_TOLERANCE, 12'd0);
		send(OP_LOAD, 16'h0000, 1'b0, 12'd0);
		send(OP_LOAD, 16'h0001, 1'b1, 12'd0);
		send(OP_READ, 16'h0000, 1'b0, 12'd1);
		drain();

		// Target below tolerance: the low band never applies.
		write_reg(CFG_TARGET, 17'd5);
		write_reg(CFG_TOLERANCE, 12'hFFF);
		write_reg(CFG_REFERENCE, 17'd0);
		send(OP_LOAD, 16'hFFFF, 1'b0, 12'd0);
		send(OP_LOAD, 16'hFFFE, 1'b0, 12'd0);
		send(OP_LOAD, 16'h1234, 1'b1, 12'd0);
		send(OP_READ, 16'h0000, 1'b0, 12'd0);
		send(OP_READ, 16'h0000, 1'b0, 12'd2);
		drain();

		// Overflow: fill the store at full rate, drop a few, close on a dropped load.
		write_reg(CFG_TARGET, 17'd30000);
		write_reg(CFG_REFERENCE, 17'd49152);
		write_reg(CFG_TOLERANCE, 12'd7);
		tx_gap_max = 0;
		for (int i = 0; i < MAX_SAMPLES + 3; i++)
			send(OP_LOAD, 16'($urandom), i == MAX_SAMPLES + 2, 12'd0);
		send(OP_READ, 16'h0000, 1'b0, 12'hFFF);
		send(OP_READ, 16'h0000, 1'b0, 12'd0);
		// Long receiver hold-off while reads keep coming, so the input stalls.
		@(negedge clk);
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send(OP_READ, 16'h0000, 1'b0, 12'($urandom));
		tx_gap_max = 8;
		drain();
		items = 0;

		// Random images with register changes between them.
		n_img = 0;
		while (items < 1850) begin
			if ($urandom_range(0, 3) == 0) begin
				tx_gap_max = 0;
				rx_gap_max = 0;
			end else begin
				tx_gap_max = 8;
				rx_gap_max = 8;
			end
			if ($urandom_range(0, 2) == 0) begin
				drain();
				write_reg(CFG_TARGET, pick_q());
				write_reg(CFG_REFERENCE, pick_q());
				write_reg(CFG_TOLERANCE, ($urandom_range(0, 3) == 0) ? 12'hFFF :
					($urandom_range(0, 2) == 0) ? 12'd0 : 12'($urandom_range(0, 64)));
			end
			run_image(($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
				: $urandom_range(1, 24), $urandom_range(0, 12));
			n_img++;
		end

		tx_gap_max = 0;
		drain();
		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/acp_pkg.sv
sv/acp_div.sv
sv/alpha_coverage_preserve_unit.sv
tb/alpha_coverage_check.sv
tb/alpha_coverage_preserve_unit_test.sv
